[hw/rtl/llq_pkg.sv]
// shared types and constants for the linked list queue manager
package llq_pkg;

   // default size of the element pool
   localparam int ELEMENTS_DEFAULT = 16;

   // fixed field widths of the stream beats
   localparam int ELEM_W  = 4;
   localparam int COUNT_W = 5;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_LINKED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_APP,
      S_REM
   } state_type;

endpackage

[hw/rtl/linked_list_queue_manager_unit.sv]
// top level of the circular doubly linked queue manager
//
// channel  dir  tdata                                  tuser
// req      in   [3:0] element, [7:4] zero              [0] mode (0 append, 1 remove)
// rsp      out  [3:0] removed_element, [8:4] count,    [1:0] status
//               [12:9] head_element, [13] queue_empty,
//               [15:14] zero
//
// an error, an append to an empty queue and a remove of the only element end in
// idle; an append to a filled queue goes through S_APP and any other remove
// through S_REM, as each pointer memory has one write port and registered read
// reset clears the linked flags, the count, the head and the sequencer; the
// pointer memories are not cleared, an entry is read only after it was written
// a new beat is taken only in idle and while the result register is free or
// being drained in the same cycle
module linked_list_queue_manager_unit
   import llq_pkg::*;
#(
   parameter int ELEMENTS = ELEMENTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] element, [7:4] zero
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] removed_element, [8:4] entry_count,
                                    // [12:9] head_element, [13] queue_empty
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int PTR_W = $clog2(ELEMENTS);
   localparam int CNT_W = $clog2(ELEMENTS + 1);

   // registers
   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ELEMENTS-1:0]   linked_ff, linked_in;
   logic [PTR_W-1:0]      elem_ff, elem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ELEM_W-1:0]     rsp_removed_ff, rsp_removed_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [ELEM_W-1:0]     rsp_head_ff, rsp_head_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   // memory ports
   logic                  nxt_we, prv_we;
   logic [PTR_W-1:0]      nxt_waddr, prv_waddr;
   logic [PTR_W-1:0]      nxt_wdata, prv_wdata;
   logic [PTR_W-1:0]      nxt_rdata, prv_rdata;

   // decoded request
   logic                  req_accept;
   logic                  mode;
   logic [ELEM_W-1:0]     element;
   logic [PTR_W-1:0]      e_ptr;
   logic                  in_pool;
   logic                  is_linked;

   // result staging
   logic                  res_load;
   status_type            res_status;
   logic [PTR_W-1:0]      res_removed;
   logic [CNT_W-1:0]      res_count;
   logic [PTR_W-1:0]      res_head;

   assign mode       = req_tuser;
   assign element    = req_tdata[ELEM_W-1:0];
   assign e_ptr      = PTR_W'(element);
   assign in_pool    = int'(element) < ELEMENTS;
   assign is_linked  = in_pool && linked_ff[e_ptr];
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   // next and prev pointer memories, both read at the requested element
   llq_ptr_ram #(
      .DEPTH  (ELEMENTS),
      .ADDR_W (PTR_W)
   ) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_waddr),
      .wr_data (nxt_wdata),
      .rd_addr (e_ptr),
      .rd_data (nxt_rdata)
   );

   llq_ptr_ram #(
      .DEPTH  (ELEMENTS),
      .ADDR_W (PTR_W)
   ) u_prv_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_waddr),
      .wr_data (prv_wdata),
      .rd_addr (e_ptr),
      .rd_data (prv_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         linked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         linked_ff    <= linked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tail_ff        <= tail_in;
      elem_ff        <= elem_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   // sequencer: decode, pointer writes and result
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      linked_in   = linked_ff;
      elem_in     = elem_ff;
      nxt_we      = 1'b0;
      prv_we      = 1'b0;
      nxt_waddr   = e_ptr;
      prv_waddr   = e_ptr;
      nxt_wdata   = e_ptr;
      prv_wdata   = e_ptr;
      res_load    = 1'b0;
      res_status  = ST_OK;
      res_removed = '0;
      res_count   = count_ff;
      res_head    = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_load = 1'b1;
               if (!mode) begin
                  // append at tail
                  if (!in_pool) begin
                     res_status = ST_ABSENT;
                  end else if (is_linked) begin
                     res_status = ST_LINKED;
                  end else begin
                     linked_in[e_ptr] = 1'b1;
                     count_in         = count_ff + 1'b1;
                     res_count        = count_ff + 1'b1;
                     tail_in          = e_ptr;
                     if (count_ff == '0) begin
                        // element links to itself
                        head_in  = e_ptr;
                        res_head = e_ptr;
                        nxt_we   = 1'b1;
                        prv_we   = 1'b1;
                     end else begin
                        // old tail points forward to the new element
                        nxt_we    = 1'b1;
                        nxt_waddr = tail_ff;
                        nxt_wdata = e_ptr;
                        prv_we    = 1'b1;
                        prv_wdata = tail_ff;
                        elem_in   = e_ptr;
                        state_in  = S_APP;
                     end
                  end
               end else begin
                  // remove named element
                  if (count_ff == '0) begin
                     res_status = ST_EMPTY;
                  end else if (!is_linked) begin
                     res_status = ST_ABSENT;
                  end else begin
                     linked_in[e_ptr] = 1'b0;
                     count_in         = count_ff - 1'b1;
                     if (count_ff == CNT_W'(1)) begin
                        head_in     = '0;
                        res_count   = '0;
                        res_head    = '0;
                        res_removed = e_ptr;
                     end else begin
                        // wait for the neighbor pointers
                        res_load = 1'b0;
                        elem_in  = e_ptr;
                        state_in = S_REM;
                     end
                  end
               end
            end
         end
         S_APP: begin
            // new element closes the ring back to the head
            nxt_we    = 1'b1;
            nxt_waddr = elem_ff;
            nxt_wdata = head_ff;
            prv_we    = 1'b1;
            prv_waddr = head_ff;
            prv_wdata = elem_ff;
            state_in  = S_IDLE;
         end
         S_REM: begin
            // unlink: before.next = after, after.prev = before
            nxt_we      = 1'b1;
            nxt_waddr   = prv_rdata;
            nxt_wdata   = nxt_rdata;
            prv_we      = 1'b1;
            prv_waddr   = nxt_rdata;
            prv_wdata   = prv_rdata;
            if (head_ff == elem_ff) begin
               head_in = nxt_rdata;
            end
            if (tail_ff == elem_ff) begin
               tail_in = prv_rdata;
            end
            res_load    = 1'b1;
            res_removed = elem_ff;
            res_head    = (head_ff == elem_ff) ? nxt_rdata : head_ff;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_empty_in   = rsp_empty_ff;
      if (res_load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status;
         rsp_removed_in = ELEM_W'(res_removed);
         rsp_count_in   = COUNT_W'(res_count);
         rsp_head_in    = (res_count != '0) ? ELEM_W'(res_head) : '0;
         rsp_empty_in   = (res_count == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_empty_ff, rsp_head_ff, rsp_count_ff, rsp_removed_ff};

   // count always matches the number of linked elements
   a_count_flags: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(linked_ff)))
      else $error("count register disagrees with linked flags");

   // an empty queue keeps its head at zero
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0))
      else $error("head not cleared on empty queue");

   // the remove result lands in a free result register
   a_rem_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM) |-> !rsp_valid_ff)
      else $error("result register busy when remove completes");

   // between items the head is a linked element
   a_head_linked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff != '0) |-> linked_ff[head_ff])
      else $error("head element is not linked");

endmodule

[hw/rtl/llq_ptr_ram.sv]
// pointer memory: one write port, one registered read port
module llq_ptr_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ADDR_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ADDR_W-1:0] rd_data
);

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
